FILE: rtl/core/cosine_similarity_engine_macros.svh
// assertion helpers for the cosine similarity engine
`ifndef COSINE_SIMILARITY_ENGINE_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clock, quiet while reset is high
`define CSE_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, quiet while reset is high
`define CSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/cse_pkg.sv
package cse_pkg;

   // element and result format
   localparam int ELEM_W = 16;
   localparam int FRAC_W = 15;
   localparam int PROD_W = 32;

   // saturation limits of the q1.15 result
   localparam logic [ELEM_W-1:0] COS_MAX = 16'h7fff;
   localparam logic [ELEM_W-1:0] COS_MIN = 16'h8000;

   // queue between accumulator and solver
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   // quotient bit counter
   localparam int DIV_CNT_W = $clog2(FRAC_W);

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ROOT,
      BK_MULT,
      BK_CHECK,
      BK_DIVIDE,
      BK_RESULT
   } back_state_type;

   typedef struct packed {
      logic too_long;
      logic zero_norm;
   } rsp_flags_type;

endpackage

FILE: rtl/core/cse_queue.sv
module cse_queue #(
   parameter int WIDTH = 122
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output logic                      empty,
   output logic [cse_pkg::QLVL_W-1:0] level
);
   import cse_pkg::*;

   logic [WIDTH-1:0]  mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + QLVL_W'(push) - QLVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (level_ff == '0);
   assign level    = level_ff;

endmodule

FILE: rtl/core/cse_front.sv
module cse_front #(
   parameter int MAX_LEN = 512,
   parameter int SQ_W    = 40,
   parameter int DOT_W   = 41,
   parameter int CNT_W   = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic signed [cse_pkg::ELEM_W-1:0] elem_a,
   input  logic signed [cse_pkg::ELEM_W-1:0] elem_b,
   input  logic                             last,
   input  logic [cse_pkg::QLVL_W-1:0]       q_level,
   output logic                             q_push,
   output logic [DOT_W-1:0]                 q_dot,
   output logic [SQ_W-1:0]                  q_sqa,
   output logic [SQ_W-1:0]                  q_sqb,
   output logic                             q_too_long
);
   import cse_pkg::*;

   // product stage
   logic                     p_valid_ff;
   logic                     p_last_ff;
   logic signed [PROD_W-1:0] p_ab_ff;
   logic signed [PROD_W-1:0] p_aa_ff;
   logic signed [PROD_W-1:0] p_bb_ff;

   // running sums
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic [SQ_W-1:0]         sqa_ff, sqa_in;
   logic [SQ_W-1:0]         sqb_ff, sqb_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    ovf_ff, ovf_in;

   logic                    accept;
   logic                    take;
   logic [QLVL_W:0]         lvl_sum;
   logic signed [DOT_W-1:0] dot_sum;
   logic [SQ_W-1:0]         sqa_sum;
   logic [SQ_W-1:0]         sqb_sum;

   // hold off while a vector end could find the queue full
   assign lvl_sum    = {1'b0, q_level} + (QLVL_W + 1)'(p_valid_ff & p_last_ff);
   assign req_tready = (lvl_sum < (QLVL_W + 1)'(QUEUE_DEPTH));
   assign accept     = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= accept;
      end
   end

   // element products, one pair per transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         p_last_ff <= last;
         p_ab_ff   <= elem_a * elem_b;
         p_aa_ff   <= elem_a * elem_a;
         p_bb_ff   <= elem_b * elem_b;
      end
   end

   // accumulate while under the length limit
   always_comb begin
      take    = p_valid_ff && (cnt_ff < CNT_W'(MAX_LEN));
      dot_sum = take ? dot_ff + DOT_W'(p_ab_ff) : dot_ff;
      sqa_sum = take ? sqa_ff + SQ_W'(p_aa_ff[PROD_W-2:0]) : sqa_ff;
      sqb_sum = take ? sqb_ff + SQ_W'(p_bb_ff[PROD_W-2:0]) : sqb_ff;

      dot_in = dot_ff;
      sqa_in = sqa_ff;
      sqb_in = sqb_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (p_valid_ff) begin
         if (p_last_ff) begin
            dot_in = '0;
            sqa_in = '0;
            sqb_in = '0;
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            dot_in = dot_sum;
            sqa_in = sqa_sum;
            sqb_in = sqb_sum;
            cnt_in = take ? cnt_ff + 1'b1 : cnt_ff;
            ovf_in = ovf_ff | ~take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         sqa_ff <= '0;
         sqb_ff <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         dot_ff <= dot_in;
         sqa_ff <= sqa_in;
         sqb_ff <= sqb_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   // finished totals go to the solver
   assign q_push     = p_valid_ff & p_last_ff;
   assign q_dot      = dot_sum;
   assign q_sqa      = sqa_sum;
   assign q_sqb      = sqb_sum;
   assign q_too_long = ovf_ff | ~take;

endmodule

FILE: rtl/core/cse_back.sv
module cse_back #(
   parameter int SQ_W  = 40,
   parameter int DOT_W = 41
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_pop,
   input  logic [DOT_W-1:0]                q_dot,
   input  logic [SQ_W-1:0]                 q_sqa,
   input  logic [SQ_W-1:0]                 q_sqb,
   input  logic                            q_too_long,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cse_pkg::ELEM_W-1:0]      rsp_cosine,
   output cse_pkg::rsp_flags_type          rsp_flags
);
   import cse_pkg::*;

   localparam int RT_W  = (SQ_W + 1) / 2;
   localparam int XW    = 2 * RT_W;
   localparam int DEN_W = 2 * RT_W;
   localparam logic [XW-1:0] BIT_START = {2'b01, {(XW - 2){1'b0}}};

   // one digit of the square root: returns {remainder, partial root}
   function automatic logic [2*XW-1:0] sqrt_step(
      input logic [XW-1:0] x,
      input logic [XW-1:0] res,
      input logic [XW-1:0] bit_v
   );
      logic [XW-1:0] trial;
      trial = res + bit_v;
      if (x >= trial) begin
         sqrt_step = {x - trial, (res >> 1) + bit_v};
      end else begin
         sqrt_step = {x, res >> 1};
      end
   endfunction

   back_state_type state_ff, state_in;

   logic [XW-1:0]        xa_ff, xa_in, ra_ff, ra_in;
   logic [XW-1:0]        xb_ff, xb_in, rb_ff, rb_in;
   logic [XW-1:0]        bit_ff, bit_in;
   logic [DOT_W-1:0]     mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic                 tl_ff, tl_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [FRAC_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [ELEM_W-1:0]    cos_ff, cos_in;
   logic                 zn_ff, zn_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]    rsp_cos_ff;
   rsp_flags_type        rsp_flags_ff;

   logic [2*XW-1:0]      step_a, step_b;
   logic [DEN_W:0]       rem_sh;
   logic                 rem_ge;
   logic [FRAC_W-1:0]    quo_next;
   logic                 den_zero;
   logic                 saturate;
   logic                 out_free;

   always_comb begin
      step_a   = sqrt_step(xa_ff, ra_ff, bit_ff);
      step_b   = sqrt_step(xb_ff, rb_ff, bit_ff);
      rem_sh   = {rem_ff, 1'b0};
      rem_ge   = (rem_sh >= {1'b0, den_ff});
      quo_next = {quo_ff[FRAC_W-2:0], rem_ge};
      den_zero = (den_ff == '0);
      saturate = (DOT_W'(den_ff) <= mag_ff);
      out_free = ~rsp_valid_ff | rsp_tready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) state_in = BK_ROOT;
         end
         BK_ROOT: begin
            if (bit_ff[0]) state_in = BK_MULT;
         end
         BK_MULT: begin
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            state_in = (den_zero || saturate) ? BK_RESULT : BK_DIVIDE;
         end
         BK_DIVIDE: begin
            if (dcnt_ff == DIV_CNT_W'(FRAC_W - 1)) state_in = BK_RESULT;
         end
         BK_RESULT: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and outputs per state
   always_comb begin
      q_pop        = 1'b0;
      xa_in        = xa_ff;
      xb_in        = xb_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      bit_in       = bit_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      tl_in        = tl_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      cos_in       = cos_ff;
      zn_in        = zn_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         BK_IDLE: begin
            q_pop  = q_valid;
            xa_in  = XW'(q_sqa);
            xb_in  = XW'(q_sqb);
            ra_in  = '0;
            rb_in  = '0;
            bit_in = BIT_START;
            neg_in = q_dot[DOT_W-1];
            mag_in = q_dot[DOT_W-1] ? (~q_dot + 1'b1) : q_dot;
            tl_in  = q_too_long;
         end
         BK_ROOT: begin
            {xa_in, ra_in} = step_a;
            {xb_in, rb_in} = step_b;
            bit_in         = bit_ff >> 2;
         end
         BK_MULT: begin
            den_in = ra_ff[RT_W-1:0] * rb_ff[RT_W-1:0];
         end
         BK_CHECK: begin
            zn_in   = den_zero;
            rem_in  = mag_ff[DEN_W-1:0];
            quo_in  = '0;
            dcnt_in = '0;
            if (den_zero) begin
               cos_in = '0;
            end else if (saturate) begin
               cos_in = neg_ff ? COS_MIN : COS_MAX;
            end
         end
         BK_DIVIDE: begin
            rem_in  = rem_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
            quo_in  = quo_next;
            dcnt_in = dcnt_ff + 1'b1;
            cos_in  = neg_ff ? (~{1'b0, quo_next} + 1'b1) : {1'b0, quo_next};
         end
         BK_RESULT: begin
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xa_ff   <= xa_in;
      xb_ff   <= xb_in;
      ra_ff   <= ra_in;
      rb_ff   <= rb_in;
      bit_ff  <= bit_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      tl_ff   <= tl_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
      cos_ff  <= cos_in;
      zn_ff   <= zn_in;
   end

   // result register, loaded as the slot frees
   always_ff @(posedge clock) begin
      if (state_ff == BK_RESULT && out_free) begin
         rsp_cos_ff             <= cos_ff;
         rsp_flags_ff.zero_norm <= zn_ff;
         rsp_flags_ff.too_long  <= tl_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_cosine = rsp_cos_ff;
   assign rsp_flags  = rsp_flags_ff;

endmodule

FILE: rtl/core/cosine_similarity_engine.sv
// channel  | direction | tdata (low bit first)   | tuser / tlast
// ---------+-----------+-------------------------+---------------------------
// req_     | in        | elem_a[15:0], elem_b    | tlast = last
// rsp_     | out       | cosine[15:0]            | tuser = zero_norm, too_long
//
// element pairs are taken one per cycle while req_tready is high; the accumulator never stalls on its own.
// after the last pair the totals pass the product register into the queue and are popped;
// both roots are then taken digit by digit side by side, followed by a multiply, a check,
// 15 quotient bits and the output register; the quotient bits are skipped when the cosine
// saturates or a norm is zero.
// the solver handles one vector at a time, so the two-entry queue fills and req_tready
// drops when vectors arrive faster than the solver finishes them.
// reset clears the accumulator sums and length counter and empties the queue.
`include "cosine_similarity_engine_macros.svh"

module cosine_similarity_engine #(
   parameter int MAX_LEN = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // elem_a [15:0], elem_b [31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // cosine [15:0]
   output logic [1:0]  rsp_tuser    // zero_norm [0], too_long [1]
);
   import cse_pkg::*;

   localparam int SQ_W   = 31 + $clog2(MAX_LEN);
   localparam int DOT_W  = SQ_W + 1;
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int ITEM_W = DOT_W + 2 * SQ_W + 1;

   logic              q_push;
   logic              q_pop;
   logic              q_empty;
   logic [QLVL_W-1:0] q_level;
   logic [DOT_W-1:0]  f_dot, b_dot;
   logic [SQ_W-1:0]   f_sqa, b_sqa;
   logic [SQ_W-1:0]   f_sqb, b_sqb;
   logic              f_tl, b_tl;
   logic [ITEM_W-1:0] q_out;
   rsp_flags_type     flags;

   // accumulating front
   cse_front #(
      .MAX_LEN (MAX_LEN),
      .SQ_W    (SQ_W),
      .DOT_W   (DOT_W),
      .CNT_W   (CNT_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .elem_a     (req_tdata[15:0]),
      .elem_b     (req_tdata[31:16]),
      .last       (req_tlast),
      .q_level    (q_level),
      .q_push     (q_push),
      .q_dot      (f_dot),
      .q_sqa      (f_sqa),
      .q_sqb      (f_sqb),
      .q_too_long (f_tl)
   );

   // totals waiting for the solver
   cse_queue #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_tl, f_sqb, f_sqa, f_dot}),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty),
      .level     (q_level)
   );

   assign {b_tl, b_sqb, b_sqa, b_dot} = q_out;

   // root, multiply and divide back end
   cse_back #(
      .SQ_W  (SQ_W),
      .DOT_W (DOT_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (~q_empty),
      .q_pop      (q_pop),
      .q_dot      (b_dot),
      .q_sqa      (b_sqa),
      .q_sqb      (b_sqb),
      .q_too_long (b_tl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_cosine (rsp_tdata),
      .rsp_flags  (flags)
   );

   assign rsp_tuser = flags;

   // checks
   `CSE_ASSERT_IMPLIES(a_zero_norm_cos, rsp_tvalid && rsp_tuser[0], rsp_tdata == 16'h0000, "zero norm with non-zero cosine")
   `CSE_ASSERT_IMPLIES(a_queue_room, q_push, q_level < QLVL_W'(QUEUE_DEPTH), "push into a full queue")
   `CSE_ASSERT_NEXT(a_push_lands, q_push, !q_empty, "pushed totals not held in the queue")

endmodule

FILE: test/tb_cosine_similarity_engine.sv
`timescale 1ns / 100ps

module tb_cosine_similarity_engine;
   import cse_pkg::*;

   localparam int MAX_LEN      = 512;
   localparam int RAND_PAIRS   = 1400;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int STALL_LIMIT  = 5000;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [2*ELEM_W-1:0]      req_tdata  = '0;   // elem_a [15:0], elem_b [31:16]
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [ELEM_W-1:0]        rsp_tdata;         // cosine [15:0]
   logic [1:0]               rsp_tuser;         // zero_norm [0], too_long [1]

   int unsigned results_seen = 0;
   int unsigned burst_left   = 0;
   int unsigned stall_cycles = 0;

   typedef struct {
      logic signed [ELEM_W-1:0] cosine;
      logic                     zero_norm;
      logic                     too_long;
   } cos_result_type;

   // expected cosine results, built from the accepted element pairs
   class cosine_scoreboard;
      longint           dot_sum;
      longint unsigned  energy_a;
      longint unsigned  energy_b;
      int unsigned      pair_count;
      bit               overran;
      cos_result_type   expected_q[$];
      int unsigned      mismatches;

      function new();
         clear_sums();
         mismatches = 0;
      endfunction

      function void clear_sums();
         dot_sum    = 0;
         energy_a   = 0;
         energy_b   = 0;
         pair_count = 0;
         overran    = 1'b0;
      endfunction

      // floor square root, one result digit per step
      function longint unsigned floor_sqrt(longint unsigned v);
         longint unsigned root  = 0;
         longint unsigned rest  = v;
         longint unsigned probe = 64'd1 << 62;
         while (probe > rest) probe >>= 2;
         while (probe != 0) begin
            if (rest >= root + probe) begin
               rest -= root + probe;
               root = (root >> 1) + probe;
            end else begin
               root >>= 1;
            end
            probe >>= 2;
         end
         return root;
      endfunction

      // one accepted pair; a last pair closes the vectors and queues a result
      function void note_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
                              logic last);
         longint          pa = a;
         longint          pb = b;
         longint unsigned den;
         longint unsigned mag;
         longint unsigned quot;
         cos_result_type  res;
         if (pair_count < MAX_LEN) begin
            dot_sum  += pa * pb;
            energy_a += longint'(pa * pa);
            energy_b += longint'(pb * pb);
            pair_count++;
         end else begin
            overran = 1'b1;
         end
         if (!last) return;
         den           = floor_sqrt(energy_a) * floor_sqrt(energy_b);
         res.zero_norm = (den == 0);
         res.too_long  = overran;
         res.cosine    = '0;
         if (!res.zero_norm) begin
            mag  = (dot_sum < 0) ? longint'(-dot_sum) : dot_sum;
            quot = (mag << FRAC_W) / den;
            if (dot_sum < 0)
               res.cosine = (quot >= 32768) ? COS_MIN : ELEM_W'(-longint'(quot));
            else
               res.cosine = (quot >= 32767) ? COS_MAX : ELEM_W'(quot);
         end
         expected_q.insert(expected_q.size(), res);
         clear_sums();
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(logic signed [ELEM_W-1:0] cosine, logic zero_norm, logic too_long);
         cos_result_type exp_res;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing expected", cosine));
            return;
         end
         exp_res = expected_q.pop_front();
         if (cosine !== exp_res.cosine)
            report_mismatch($sformatf("cosine got %0d expected %0d", cosine, exp_res.cosine));
         if (zero_norm !== exp_res.zero_norm)
            report_mismatch($sformatf("zero_norm got %0b expected %0b",
                                      zero_norm, exp_res.zero_norm));
         if (too_long !== exp_res.too_long)
            report_mismatch($sformatf("too_long got %0b expected %0b",
                                      too_long, exp_res.too_long));
      endtask
   endclass

   cosine_scoreboard sb = new();

   cosine_similarity_engine #(
      .MAX_LEN (MAX_LEN)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // element values weighted towards the extremes
   function automatic logic signed [ELEM_W-1:0] pick_elem();
      case ($urandom_range(0, 9))
         0:       return COS_MIN;
         1:       return COS_MAX;
         2:       return '0;
         3:       return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
         4, 5:    return ELEM_W'($urandom_range(0, 511)) - 16'sd256;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   // offer one pair and wait for its transaction; bursts with random gaps
   task send_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b, logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pair(a, b, last);
   endtask

   // receiver: phases of different readiness, plus one long hold-off
   initial begin
      int unsigned ready_pct;
      int unsigned phase_len;
      bit          held;
      held = 1'b0;
      forever begin
         case ($urandom_range(0, 4))
            0, 1:    ready_pct = 100;
            2:       ready_pct = 75;
            3:       ready_pct = 50;
            default: ready_pct = 15;
         endcase
         phase_len = $urandom_range(20, 150);
         repeat (phase_len) begin
            if (!held && results_seen >= 12) begin
               held = 1'b1;
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
            @(posedge clock);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_flags_type flags;
      flags = rsp_tuser;
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result($signed(rsp_tdata), flags.zero_norm, flags.too_long);
         results_seen++;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL cosine_similarity_engine");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus
   initial begin
      int unsigned              sent;
      int unsigned              vec_idx;
      int unsigned              len;
      int unsigned              mode;
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, saturation both ways, zero norm, orthogonal
      send_pair(COS_MAX, COS_MAX, 1'b1);
      send_pair(COS_MIN, COS_MIN, 1'b1);
      send_pair(COS_MIN, COS_MAX, 1'b1);
      send_pair(16'sd0, 16'sd12345, 1'b1);
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(16'sd100, -16'sd100, 1'b0);
      send_pair(16'sd200, -16'sd200, 1'b1);
      send_pair(16'sd3, 16'sd4, 1'b0);
      send_pair(16'sd4, -16'sd3, 1'b1);
      send_pair(COS_MAX, COS_MIN, 1'b0);
      send_pair(COS_MIN, COS_MAX, 1'b0);
      send_pair(COS_MAX, COS_MIN, 1'b1);
      send_pair(-16'sd1, -16'sd1, 1'b1);
      send_pair(16'sd1, COS_MAX, 1'b0);
      send_pair(COS_MAX, 16'sd1, 1'b1);

      // random vectors, mostly short, one at the length limit and one over it
      sent    = 0;
      vec_idx = 0;
      while (sent < RAND_PAIRS) begin
         if (vec_idx == 10)
            len = MAX_LEN;
         else if (vec_idx == 30)
            len = MAX_LEN + $urandom_range(1, 24);
         else if ($urandom_range(0, 7) == 0)
            len = $urandom_range(13, 40);
         else
            len = $urandom_range(1, 12);
         mode = $urandom_range(0, 5);
         for (int unsigned i = 0; i < len; i++) begin
            a = pick_elem();
            case (mode)
               1:       b = a;
               2:       b = -a;
               3:       b = a + ELEM_W'($urandom_range(0, 63)) - 16'sd32;
               4: begin
                  b = pick_elem();
                  a = '0;
               end
               default: b = pick_elem();
            endcase
            send_pair(a, b, i == len - 1);
            sent++;
         end
         vec_idx++;
      end
      req_tvalid <= 1'b0;

      // drain
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0)
         $display("PASS cosine_similarity_engine");
      else
         $display("FAIL cosine_similarity_engine");
      $finish;
   end

endmodule
